@@ rtl/core/decimal_frequency_text_parser_macros.svh @@
// Assertion helpers for the parser core. They expect clk and rst_n in scope.
`ifndef DECIMAL_FREQUENCY_TEXT_PARSER_MACROS_SVH
`define DECIMAL_FREQUENCY_TEXT_PARSER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DFP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DFP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/dfp_pkg.sv @@
package dfp_pkg;

    localparam int unsigned VALUE_W = 64;
    localparam int unsigned SUM_W   = VALUE_W + 4;
    localparam int unsigned COUNT_W = 5;
    localparam int unsigned NUM_POW = 20;

    localparam logic [7:0] CHAR_0     = 8'h30;
    localparam logic [7:0] CHAR_9     = 8'h39;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;

    localparam logic [VALUE_W-1:0] UNIT_RESET = 64'd1;

    // Powers of ten that fit in 64 bits, 10^0 through 10^19.
    localparam logic [VALUE_W-1:0] POW10 [NUM_POW] = '{
        64'd1,
        64'd10,
        64'd100,
        64'd1000,
        64'd10000,
        64'd100000,
        64'd1000000,
        64'd10000000,
        64'd100000000,
        64'd1000000000,
        64'd10000000000,
        64'd100000000000,
        64'd1000000000000,
        64'd10000000000000,
        64'd100000000000000,
        64'd1000000000000000,
        64'd10000000000000000,
        64'd100000000000000000,
        64'd1000000000000000000,
        64'd10000000000000000000
    };

    typedef enum logic [1:0] {
        PHASE_LEAD  = 2'd0,
        PHASE_BODY  = 2'd1,
        PHASE_TRAIL = 2'd2
    } phase_t;

    typedef struct packed {
        logic               ok;
        logic [COUNT_W-1:0] exp;
    } unit_info_t;

    // Operand set for the shared multiply-by-ten-and-add unit.
    typedef struct packed {
        logic               mul10;
        logic [VALUE_W-1:0] a;
        logic [VALUE_W-1:0] b;
    } mac_req_t;

    function automatic unit_info_t decode_unit(input logic [VALUE_W-1:0] unit);
        unit_info_t info;
        info.ok  = 1'b0;
        info.exp = '0;
        for (int k = 0; k < NUM_POW; k++)
        begin
            if (unit == POW10[k])
            begin
                info.ok  = 1'b1;
                info.exp = COUNT_W'(k);
            end
        end
        return info;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CHAR_SPACE) || (c inside {[CHAR_TAB:CHAR_CR]});
    endfunction

endpackage

@@ rtl/core/dfp_channels.sv @@
interface dfp_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;
    logic       char_present;
    logic       end_of_text;

    modport source (output valid, character, char_present, end_of_text, input ready);
    modport sink   (input valid, character, char_present, end_of_text, output ready);
endinterface

interface dfp_result_if;
    logic        valid;
    logic        ready;
    logic [63:0] frequency_hz;
    logic        valid_res;

    modport source (output valid, frequency_hz, valid_res, input ready);
    modport sink   (input valid, frequency_hz, valid_res, output ready);
endinterface

@@ rtl/core/decimal_frequency_text_parser.sv @@
// Decimal frequency text parser.
// The text channel carries one byte per transfer with char_present and
// end_of_text flags; the result channel gives one transfer per text, on the
// item that has end_of_text set, with frequency_hz and valid_res. The unit
// register is written through cfg_we/cfg_wdata and must be 10^E, E <= 19.
// Each text item is accepted in the idle state; an item with a character is
// then handled by one pass of the shared multiply-by-ten unit, and the core
// is not ready while it does so. The end item adds a check, padding of the
// fraction to E digits, scaling of the whole part by ten E times (on the same
// shared unit), one final add and the load of the output register; a text
// that fails the check or overflows goes straight to the load.
// The output register holds a result until the receiver takes it. A new text
// may be fed while a result waits; a stalled receiver stops the next end item
// in its final state, with the text channel not ready, until the output frees.
// Reset clears the text state, empties the output and sets the unit to 1.
`include "decimal_frequency_text_parser_macros.svh"

module decimal_frequency_text_parser (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [63:0]          cfg_wdata,
    dfp_text_if.sink             text,
    dfp_result_if.source         result
);

    // Sequencer states: take a byte, handle it, then the finishing steps.
    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_CHAR  = 7'b0000010,
        ST_CHECK = 7'b0000100,
        ST_PAD   = 7'b0001000,
        ST_MUL   = 7'b0010000,
        ST_ADD   = 7'b0100000,
        ST_DONE  = 7'b1000000
    } state_t;

    localparam int unsigned VW = dfp_pkg::VALUE_W;
    localparam int unsigned CW = dfp_pkg::COUNT_W;

    state_t                 state_reg,   state_next;
    dfp_pkg::unit_info_t    unit_reg,    unit_next;
    logic [VW-1:0]          whole_reg,   whole_next;
    logic [VW-1:0]          frac_reg,    frac_next;
    logic [CW-1:0]          count_reg,   count_next;
    logic [CW-1:0]          step_reg,    step_next;
    logic                   digit_reg,   digit_next;
    logic                   sep_reg,     sep_next;
    dfp_pkg::phase_t        phase_reg,   phase_next;
    logic                   failed_reg,  failed_next;
    logic                   res_ok_reg,  res_ok_next;
    logic [7:0]             char_reg,    char_next;
    logic                   end_reg,     end_next;
    logic                   out_valid_reg, out_valid_next;
    logic [VW-1:0]          out_freq_reg,  out_freq_next;
    logic                   out_ok_reg,    out_ok_next;

    dfp_pkg::mac_req_t      mac_req;
    logic [dfp_pkg::SUM_W-1:0] mac_sum;
    logic                   mac_ovf;
    logic                   take;
    logic                   out_free;
    logic                   is_digit;
    logic                   is_sep;
    logic                   blank;
    logic [3:0]             digit_val;

    // The single arithmetic unit that every multiply-by-ten and add goes through.
    dfp_mac10 u_mac (
        .req (mac_req),
        .sum (mac_sum)
    );

    assign mac_ovf   = |mac_sum[dfp_pkg::SUM_W-1:VW];
    assign take      = text.valid && text.ready;
    assign out_free  = !out_valid_reg || result.ready;
    assign is_digit  = char_reg inside {[dfp_pkg::CHAR_0:dfp_pkg::CHAR_9]};
    assign is_sep    = (char_reg == dfp_pkg::CHAR_DOT) || (char_reg == dfp_pkg::CHAR_COMMA);
    assign blank     = dfp_pkg::is_blank(char_reg);
    assign digit_val = 4'(char_reg - dfp_pkg::CHAR_0);

    assign text.ready          = (state_reg == ST_IDLE);
    assign result.valid        = out_valid_reg;
    assign result.frequency_hz = out_freq_reg;
    assign result.valid_res    = out_ok_reg;

    // Operand selection for the shared unit, by sequencer state.
    always_comb
    begin
        mac_req.mul10 = 1'b1;
        mac_req.a     = whole_reg;
        mac_req.b     = '0;
        case (state_reg)
            ST_CHAR:
            begin
                mac_req.a = sep_reg ? frac_reg : whole_reg;
                mac_req.b = {{(VW-4){1'b0}}, digit_val};
            end
            ST_PAD:
            begin
                mac_req.a = frac_reg;
            end
            ST_ADD:
            begin
                mac_req.mul10 = 1'b0;
                mac_req.b     = frac_reg;
            end
            default:
            begin
                mac_req.a = whole_reg;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        unit_next      = unit_reg;
        whole_next     = whole_reg;
        frac_next      = frac_reg;
        count_next     = count_reg;
        step_next      = step_reg;
        digit_next     = digit_reg;
        sep_next       = sep_reg;
        phase_next     = phase_reg;
        failed_next    = failed_reg;
        res_ok_next    = res_ok_reg;
        char_next      = char_reg;
        end_next       = end_reg;
        out_freq_next  = out_freq_reg;
        out_ok_next    = out_ok_reg;
        out_valid_next = out_valid_reg && !result.ready;

        // The unit is decoded once when written, so every byte sees its exponent.
        if (cfg_we)
        begin
            unit_next = dfp_pkg::decode_unit(cfg_wdata);
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    char_next = text.character;
                    end_next  = text.end_of_text;
                    if (text.char_present)
                    begin
                        state_next = ST_CHAR;
                    end
                    else if (text.end_of_text)
                    begin
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_CHAR:
            begin
                state_next = end_reg ? ST_CHECK : ST_IDLE;
                if (!failed_reg)
                begin
                    if (phase_reg == dfp_pkg::PHASE_TRAIL)
                    begin
                        failed_next = !blank;
                    end
                    else if (blank)
                    begin
                        // Whitespace inside the body ends it.
                        if (phase_reg == dfp_pkg::PHASE_BODY)
                        begin
                            phase_next = dfp_pkg::PHASE_TRAIL;
                        end
                    end
                    else
                    begin
                        phase_next = dfp_pkg::PHASE_BODY;
                        if (is_digit)
                        begin
                            digit_next = 1'b1;
                            if (!sep_reg)
                            begin
                                if (mac_ovf)
                                begin
                                    failed_next = 1'b1;
                                end
                                else
                                begin
                                    whole_next = mac_sum[VW-1:0];
                                end
                            end
                            else if (count_reg >= unit_reg.exp)
                            begin
                                failed_next = 1'b1;
                            end
                            else
                            begin
                                frac_next  = mac_sum[VW-1:0];
                                count_next = count_reg + 1'b1;
                            end
                        end
                        else if (is_sep && !sep_reg && digit_reg)
                        begin
                            sep_next = 1'b1;
                        end
                        else
                        begin
                            failed_next = 1'b1;
                        end
                    end
                end
            end
            ST_CHECK:
            begin
                if (!unit_reg.ok || failed_reg || !digit_reg ||
                    (sep_reg && (count_reg == '0)))
                begin
                    res_ok_next = 1'b0;
                    state_next  = ST_DONE;
                end
                else
                begin
                    state_next = ST_PAD;
                end
            end
            ST_PAD:
            begin
                // Bring the fraction up to E digits.
                if (count_reg >= unit_reg.exp)
                begin
                    step_next  = '0;
                    state_next = ST_MUL;
                end
                else
                begin
                    frac_next  = mac_sum[VW-1:0];
                    count_next = count_reg + 1'b1;
                end
            end
            ST_MUL:
            begin
                // whole * 10^E as E multiply-by-ten steps, each checked for carry out.
                if (step_reg >= unit_reg.exp)
                begin
                    state_next = ST_ADD;
                end
                else if (mac_ovf)
                begin
                    res_ok_next = 1'b0;
                    state_next  = ST_DONE;
                end
                else
                begin
                    whole_next = mac_sum[VW-1:0];
                    step_next  = step_reg + 1'b1;
                end
            end
            ST_ADD:
            begin
                whole_next  = mac_sum[VW-1:0];
                res_ok_next = !mac_ovf && (mac_sum[VW-1:0] != '0);
                state_next  = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_ok_next    = res_ok_reg;
                    out_freq_next  = res_ok_reg ? whole_reg : '0;
                    whole_next     = '0;
                    frac_next      = '0;
                    count_next     = '0;
                    digit_next     = 1'b0;
                    sep_next       = 1'b0;
                    phase_next     = dfp_pkg::PHASE_LEAD;
                    failed_next    = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            unit_reg      <= dfp_pkg::decode_unit(dfp_pkg::UNIT_RESET);
            whole_reg     <= '0;
            frac_reg      <= '0;
            count_reg     <= '0;
            step_reg      <= '0;
            digit_reg     <= 1'b0;
            sep_reg       <= 1'b0;
            phase_reg     <= dfp_pkg::PHASE_LEAD;
            failed_reg    <= 1'b0;
            res_ok_reg    <= 1'b0;
            end_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            unit_reg      <= unit_next;
            whole_reg     <= whole_next;
            frac_reg      <= frac_next;
            count_reg     <= count_next;
            step_reg      <= step_next;
            digit_reg     <= digit_next;
            sep_reg       <= sep_next;
            phase_reg     <= phase_next;
            failed_reg    <= failed_next;
            res_ok_reg    <= res_ok_next;
            end_reg       <= end_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        char_reg     <= char_next;
        out_freq_reg <= out_freq_next;
        out_ok_reg   <= out_ok_next;
    end

    // A result loaded from the final state is offered in the next cycle.
    `DFP_ASSERT_NEXT(a_done_loads_output, (state_reg == ST_DONE) && out_free, out_valid_reg && (state_reg == ST_IDLE), "finished result was not loaded into the output register")

    // A valid result always carries a nonzero frequency.
    `DFP_ASSERT_NOW(a_valid_is_nonzero, out_valid_reg && out_ok_reg, out_freq_reg != '0, "valid result with zero frequency")

    // An item with neither a character nor an end mark leaves the core idle.
    `DFP_ASSERT_NEXT(a_empty_item_idle, take && !text.char_present && !text.end_of_text, state_reg == ST_IDLE, "empty item started work")

endmodule

@@ rtl/core/dfp_mac10.sv @@
// Shared arithmetic unit: sum = a * 10 + b, or a + b, with four guard bits
// so that any carry out of 64 bits shows up as overflow.
module dfp_mac10 (
    input  dfp_pkg::mac_req_t             req,
    output logic [dfp_pkg::SUM_W-1:0]     sum
);

    logic [dfp_pkg::SUM_W-1:0] a_ext;
    logic [dfp_pkg::SUM_W-1:0] b_ext;
    logic [dfp_pkg::SUM_W-1:0] a_scaled;

    assign a_ext    = {4'b0000, req.a};
    assign b_ext    = {4'b0000, req.b};
    assign a_scaled = req.mul10 ? ((a_ext << 3) + (a_ext << 1)) : a_ext;
    assign sum      = a_scaled + b_ext;

endmodule

@@ test/tb_decimal_frequency_text_parser.sv @@
// Self-checking testbench for the decimal frequency text parser.
import dfp_pkg::*;

module tb_decimal_frequency_text_parser;

    // One transfer on the text channel.
    typedef struct {
        logic [7:0] ch;
        logic       present;
        logic       eot;
    } text_item_t;

    // One result on the frequency channel.
    typedef struct {
        logic [63:0] hz;
        logic        ok;
    } freq_t;

    localparam logic [63:0] ALL_ONES = {64{1'b1}};
    localparam int unsigned NUM_PHASES = 9;
    localparam int unsigned ITEMS_PER_PHASE = 205;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam int unsigned SETTLE_CYCLES = 64;
    localparam int unsigned CYCLE_LIMIT = 400000;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [63:0] cfg_wdata;

    dfp_text_if   text_ch ();
    dfp_result_if freq_ch ();

    decimal_frequency_text_parser i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .text      (text_ch.sink),
        .result    (freq_ch.source)
    );

    always #2 clk = ~clk;

    // Items waiting to be offered, and the frequencies the parser owes us.
    text_item_t  text_items [$];
    freq_t       expected_freqs [$];
    logic [7:0]  chars [$];
    text_item_t  next_item;
    freq_t       oldest_freq;

    // Idle percentages for each side and the long receiver hold-off.
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    bit          long_stall;
    int unsigned stall_cycles;

    int unsigned errors;
    int unsigned results_seen;
    int unsigned valid_seen;
    int unsigned fed_items;
    int unsigned total_items;
    int unsigned units_written;
    int unsigned cycles;

    // Our own copy of the parser state, updated at every accepted transfer.
    logic [63:0] unit_now;
    logic [63:0] acc_whole;
    logic [63:0] acc_frac;
    logic [4:0]  frac_digits;
    logic        got_digit;
    logic        got_sep;
    logic        bad_text;
    phase_t      parse_phase;

    logic [63:0] unit_table [NUM_PHASES] = '{
        64'd1000000,
        64'd1,
        64'd10000000000000000000,
        64'd12345,
        64'd1000,
        64'd0,
        64'd1000000000,
        64'hFFFF_FFFF_FFFF_FFFF,
        64'd100
    };

    function automatic void clear_text();
        acc_whole   = '0;
        acc_frac    = '0;
        frac_digits = '0;
        got_digit   = 1'b0;
        got_sep     = 1'b0;
        bad_text    = 1'b0;
        parse_phase = PHASE_LEAD;
    endfunction

    // Returns E when the unit is exactly 10^E; ok reports whether it is.
    function automatic int unsigned unit_exponent(input logic [63:0] u, output bit ok);
        logic [63:0] s;
        int unsigned e;
        s = u;
        e = 0;
        ok = 1'b0;
        if (s == 64'd0)
            return 0;
        while (s > 64'd1 && s % 64'd10 == 64'd0)
        begin
            s = s / 64'd10;
            e++;
        end
        ok = (s == 64'd1);
        return e;
    endfunction

    function automatic bit is_space(input logic [7:0] c);
        return (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
    endfunction

    // A byte of the number body: digit, separator, or anything else fails.
    function automatic void absorb_body(input logic [7:0] c);
        bit          ok;
        int unsigned max_frac;
        logic [63:0] d;
        max_frac = unit_exponent(unit_now, ok);
        if (c >= CHAR_0 && c <= CHAR_9)
        begin
            d = 64'(c - CHAR_0);
            got_digit = 1'b1;
            if (!got_sep)
            begin
                if (acc_whole > (ALL_ONES - d) / 64'd10)
                begin
                    bad_text = 1'b1;
                    return;
                end
                acc_whole = acc_whole * 64'd10 + d;
            end
            else
            begin
                if (frac_digits >= max_frac)
                begin
                    bad_text = 1'b1;
                    return;
                end
                acc_frac = acc_frac * 64'd10 + d;
                frac_digits = frac_digits + 5'd1;
            end
            return;
        end
        if ((c == CHAR_DOT || c == CHAR_COMMA) && !got_sep && got_digit)
        begin
            got_sep = 1'b1;
            return;
        end
        bad_text = 1'b1;
    endfunction

    function automatic void absorb_char(input logic [7:0] c);
        if (bad_text)
            return;
        case (parse_phase)
            PHASE_LEAD:
            begin
                if (!is_space(c))
                begin
                    parse_phase = PHASE_BODY;
                    absorb_body(c);
                end
            end
            PHASE_BODY:
            begin
                if (is_space(c))
                    parse_phase = PHASE_TRAIL;
                else
                    absorb_body(c);
            end
            default:
            begin
                if (!is_space(c))
                    bad_text = 1'b1;
            end
        endcase
    endfunction

    // Pads the fraction to E digits and forms whole * unit + fraction.
    function automatic freq_t settle_frequency();
        freq_t       r;
        bit          ok;
        int unsigned max_frac;
        int unsigned n;
        logic [63:0] frac;
        logic [63:0] value;
        r.hz = '0;
        r.ok = 1'b0;
        max_frac = unit_exponent(unit_now, ok);
        if (!ok || bad_text || !got_digit || (got_sep && frac_digits == 0))
            return r;
        frac = acc_frac;
        n = frac_digits;
        while (n < max_frac)
        begin
            frac = frac * 64'd10;
            n++;
        end
        if (acc_whole > (ALL_ONES - frac) / unit_now)
            return r;
        value = acc_whole * unit_now + frac;
        if (value == 64'd0)
            return r;
        r.hz = value;
        r.ok = 1'b1;
        return r;
    endfunction

    function automatic void predict_transfer(input logic [7:0] c, input logic present,
                                             input logic eot);
        if (present)
            absorb_char(c);
        if (eot)
        begin
            expected_freqs.push_back(settle_frequency());
            clear_text();
        end
    endfunction

    // Driver: offers queued items, holding each one until it is accepted.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            text_ch.valid <= 1'b0;
        end
        else
        begin
            if (text_ch.valid && text_ch.ready)
                predict_transfer(text_ch.character, text_ch.char_present,
                                 text_ch.end_of_text);
            if (!text_ch.valid || text_ch.ready)
            begin
                if (text_items.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    next_item = text_items.pop_front();
                    text_ch.valid        <= 1'b1;
                    text_ch.character    <= next_item.ch;
                    text_ch.char_present <= next_item.present;
                    text_ch.end_of_text  <= next_item.eot;
                end
                else
                begin
                    text_ch.valid <= 1'b0;
                end
            end
        end
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch in %s at result %0d: got %0d, expected %0d",
                 what, results_seen, got, want);
        errors++;
    endtask

    // Monitor: checks every result transfer against the oldest expectation.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            freq_ch.ready <= 1'b0;
        end
        else
        begin
            if (freq_ch.valid && freq_ch.ready)
            begin
                if (expected_freqs.size() == 0)
                begin
                    report_mismatch("unexpected result", freq_ch.frequency_hz, 64'd0);
                end
                else
                begin
                    oldest_freq = expected_freqs.pop_front();
                    if (freq_ch.frequency_hz !== oldest_freq.hz)
                        report_mismatch("frequency_hz", freq_ch.frequency_hz, oldest_freq.hz);
                    if (freq_ch.valid_res !== oldest_freq.ok)
                        report_mismatch("valid_res", 64'(freq_ch.valid_res),
                                        64'(oldest_freq.ok));
                    if (oldest_freq.ok)
                        valid_seen++;
                end
                results_seen++;
            end
            freq_ch.ready <= !long_stall && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // The long hold-off is timed here, apart from the stimulus process.
    always @(posedge clk)
    begin
        if (!long_stall)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles with %0d results outstanding",
                     cycles, expected_freqs.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] rand_digit();
        return 8'(CHAR_0 + $urandom_range(0, 9));
    endfunction

    // Whitespace is space or any byte from tab through carriage return.
    function automatic logic [7:0] rand_blank();
        if ($urandom_range(0, 5) == 0)
            return CHAR_SPACE;
        return 8'(CHAR_TAB + $urandom_range(0, 4));
    endfunction

    // Null items (no character, no end) are sent but do not count as stimulus.
    function automatic void push_item(input logic [7:0] c, input logic present,
                                      input logic eot);
        text_item_t it;
        it.ch = c;
        it.present = present;
        it.eot = eot;
        text_items.push_back(it);
        if (present || eot)
        begin
            fed_items++;
            total_items++;
        end
    endfunction

    function automatic void queue_literal(input string s);
        for (int i = 0; i < s.len(); i++)
            push_item(s[i], 1'b1, i == s.len() - 1);
    endfunction

    // Sends the bytes in chars as one text. The end flag either rides on the
    // last byte or comes as a separate end-only item, and now and then a null
    // item slips in before a byte.
    function automatic void emit_text();
        bit end_on_char;
        end_on_char = (chars.size() != 0) && ($urandom_range(0, 1) == 1);
        for (int i = 0; i < chars.size(); i++)
        begin
            if ($urandom_range(0, 19) == 0)
                push_item(rand_byte(), 1'b0, 1'b0);
            push_item(chars[i], 1'b1, end_on_char && i == chars.size() - 1);
        end
        if (!end_on_char)
            push_item(rand_byte(), 1'b0, 1'b1);
    endfunction

    // A number, mostly well formed. Whole parts are mostly short so that scaling by
    // the unit rarely overflows, but a few run long enough to overflow 64 bits.
    // Fraction digits sometimes exceed the exponent by one.
    function automatic void build_number(input int unsigned e);
        int unsigned n_whole;
        int unsigned n_frac;
        chars.delete();
        repeat ($urandom_range(0, 2)) chars.push_back(rand_blank());
        n_whole = ($urandom_range(0, 19) == 0) ? $urandom_range(15, 21)
                                               : $urandom_range(1, 4);
        repeat (n_whole) chars.push_back(rand_digit());
        if ($urandom_range(0, 9) < 6)
        begin
            chars.push_back($urandom_range(0, 1) ? CHAR_DOT : CHAR_COMMA);
            n_frac = ($urandom_range(0, 9) == 0) ? e + 1 : $urandom_range(0, e);
            repeat (n_frac) chars.push_back(rand_digit());
        end
        repeat ($urandom_range(0, 2)) chars.push_back(rand_blank());
    endfunction

    // Spoils a well-formed number in one of several typical ways.
    function automatic void break_text();
        int unsigned pos;
        pos = $urandom_range(0, chars.size() - 1);
        case ($urandom_range(0, 4))
            0: chars[pos] = rand_byte();
            1: chars.insert(pos, rand_blank());
            2: chars.insert(pos, CHAR_DOT);
            3: chars.push_front(CHAR_COMMA);
            default: chars.push_back(rand_byte());
        endcase
    endfunction

    // Waits until everything sent has been answered, then lets the parser
    // finish any last pass before the register is touched.
    task automatic wait_idle();
        @(negedge clk);
        while (text_items.size() != 0 || text_ch.valid || expected_freqs.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_unit(input logic [63:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        unit_now   = value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        units_written++;
        @(negedge clk);
    endtask

    task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
        @(negedge clk);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
    endtask

    // One random phase under a single unit setting. A bad unit still needs an
    // exponent to shape the fractions, so three is used for it.
    task automatic run_phase(input logic [63:0] unit, input bit hold_receiver);
        bit          ok;
        int unsigned e;
        int unsigned pick;
        wait_idle();
        write_unit(unit);
        e = unit_exponent(unit, ok);
        if (!ok)
            e = 3;
        fed_items = 0;
        while (fed_items < ITEMS_PER_PHASE)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 97)
            begin
                build_number(e);
                if (pick >= 70 && pick < 85)
                    break_text();
                if (pick >= 85)
                begin
                    chars.delete();
                    repeat ($urandom_range(1, 6)) chars.push_back(rand_byte());
                end
            end
            else
            begin
                chars.delete();
            end
            emit_text();
        end
        // With the receiver held off the parser fills up and must stall the
        // text channel while the driver keeps offering.
        if (hold_receiver)
        begin
            long_stall = 1'b1;
            while (stall_cycles < HOLD_CYCLES)
                @(negedge clk);
            long_stall = 1'b0;
        end
        wait_idle();
    endtask

    initial
    begin
        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_wdata            = '0;
        text_ch.valid        = 1'b0;
        text_ch.character    = '0;
        text_ch.char_present = 1'b0;
        text_ch.end_of_text  = 1'b0;
        freq_ch.ready        = 1'b0;
        send_idle_pct        = 18;
        recv_idle_pct        = 82;
        long_stall           = 1'b0;
        stall_cycles         = 0;
        errors               = 0;
        results_seen         = 0;
        valid_seen           = 0;
        fed_items            = 0;
        total_items          = 0;
        units_written        = 0;
        cycles               = 0;
        unit_now             = UNIT_RESET;
        clear_text();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed texts under the reset unit of one hertz: an empty text,
        // a null item, whitespace around a digit, a zero value, bytes at both
        // ends of the byte range, a separator before any digit, a separator
        // with no fraction, and a stray byte after trailing whitespace.
        push_item(8'hFF, 1'b0, 1'b1);
        push_item(8'hFF, 1'b0, 1'b0);
        queue_literal("\t9 ");
        queue_literal("0");
        push_item(8'hFF, 1'b1, 1'b0);
        push_item(8'h00, 1'b1, 1'b1);
        queue_literal(".5");
        queue_literal("5.");
        queue_literal("1 2");
        wait_idle();

        // One fraction digit allowed: a comma separator, then one digit too many.
        write_unit(64'd10);
        queue_literal("3,5");
        queue_literal("3,51");
        // The unit changes in the middle of a text; the fraction digits that
        // follow are checked against the new exponent.
        push_item("4", 1'b1, 1'b0);
        push_item(CHAR_DOT, 1'b1, 1'b0);
        wait_idle();
        write_unit(64'd100);
        queue_literal("25");
        wait_idle();

        // The largest unit: one whole unit fits, two overflow.
        write_unit(64'd10000000000000000000);
        queue_literal("1");
        queue_literal("2");
        wait_idle();
        write_unit(64'd0);
        queue_literal("1");

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            if (p == 3)
                set_idling(82, 18);
            if (p == 6)
                set_idling(0, 0);
            run_phase(unit_table[p], p == 4);
        end

        if (expected_freqs.size() != 0)
            report_mismatch("results never delivered", 64'(expected_freqs.size()), 64'd0);
        $display("Checked %0d parsed texts (%0d with a valid frequency) from %0d transfers.",
                 results_seen, valid_seen, total_items);
        $display("The unit register took %0d settings, including zero and 2^64-1.",
                 units_written);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

@@ decimal_frequency_text_parser.f @@
+incdir+rtl/core
rtl/core/dfp_pkg.sv
rtl/core/dfp_channels.sv
rtl/core/dfp_mac10.sv
rtl/core/decimal_frequency_text_parser.sv
test/tb_decimal_frequency_text_parser.sv
